// ===== rtl/ffa_pkg.sv =====
// Shared types and default constants for the first-fit heap allocator.
// No dependencies; used by ffa_block_mem and first_fit_heap_allocator.
package ffa_pkg;

    localparam int ARENA_BYTES_DEF  = 4096;
    localparam int HEADER_BYTES_DEF = 17;
    localparam int MIN_CAPACITY_DEF = 24;

    // Access strobes for the block header memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator with split and coalesce, top level.
// Depends on ffa_pkg and ffa_block_mem.
//
//   channel  | handshake         | payload
//   ---------+-------------------+---------------------------------------
//   request  | start / busy      | i_func, i_req_size, i_free_addr
//   result   | o_done (1 cycle)  | o_status, o_data_addr
//
// A request is taken when start is high and busy low. A null or ignored free
// answers from idle; other frees mark the header free, absorb the next block if
// free. Allocate walks past used blocks, absorbs free followers, tests the fit,
// splits off a large enough rest and marks the header used. No clearing pass at
// reset: header 0 reads as the whole free arena until first written. Results
// cannot be stalled; o_done lasts one cycle with busy low.
module first_fit_heap_allocator #(
    parameter int ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
    parameter int MIN_CAPACITY = ffa_pkg::MIN_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [12:0] i_req_size,
    input  logic [11:0] i_free_addr,
    output logic        o_done,
    output logic        o_status,
    output logic [11:0] o_data_addr
);

    localparam int AW = $clog2(ARENA_BYTES);
    localparam int SW = ((AW > 13) ? AW : 13) + 2;

    localparam logic [SW-1:0] C_ARENA = SW'(ARENA_BYTES);
    localparam logic [SW-1:0] C_HDR   = SW'(HEADER_BYTES);
    localparam logic [SW-1:0] C_MIN   = SW'(MIN_CAPACITY);

    localparam logic FUNC_FREE = 1'b1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_A_CHK = 3'd1;
    localparam logic [2:0] S_A_HDR = 3'd2;
    localparam logic [2:0] S_F_HDR = 3'd3;
    localparam logic [2:0] S_M_RD  = 3'd4;
    localparam logic [2:0] S_M_CMP = 3'd5;
    localparam logic [2:0] S_FIT   = 3'd6;
    localparam logic [2:0] S_WR_H  = 3'd7;

    logic [2:0]    r_state, n_state;
    logic          r_func, n_func;
    logic [12:0]   r_req, n_req;
    logic [SW-1:0] r_h, n_h;
    logic [SW-1:0] r_cap, n_cap;
    logic          r_done, n_done;
    logic          r_status, n_status;
    logic [11:0]   r_addr, n_addr;

    ffa_pkg::t_mem_ctl mem_ctl;
    logic [AW-1:0] rd_addr, wr_addr, wr_cap;
    logic          wr_free;
    logic          m_free;
    logic [AW-1:0] m_cap;

    logic [SW-1:0] fa, fh, req_w, q_w, nx, mem_end, merged, room, sat, rest, rest_cap;

    ffa_block_mem #(
        .ARENA_BYTES (ARENA_BYTES),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mem_ctl),
        .i_rd_addr(rd_addr),
        .i_wr_addr(wr_addr),
        .i_wr_free(wr_free),
        .i_wr_cap (wr_cap),
        .o_rd_free(m_free),
        .o_rd_cap (m_cap)
    );

    always_comb begin
        fa       = SW'(i_free_addr);
        fh       = fa - C_HDR;
        req_w    = SW'(r_req);
        q_w      = (req_w < C_MIN) ? C_MIN : req_w;
        nx       = r_h + C_HDR + r_cap;
        mem_end  = r_h + C_HDR + SW'(m_cap);
        merged   = r_cap + C_HDR + SW'(m_cap);
        room     = C_ARENA - r_h - C_HDR;
        sat      = (merged > room) ? room : merged;
        rest     = r_h + C_HDR + q_w;
        rest_cap = r_cap - q_w - C_HDR;
    end

    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_req    = r_req;
        n_h      = r_h;
        n_cap    = r_cap;
        n_done   = 1'b0;
        n_status = r_status;
        n_addr   = r_addr;
        mem_ctl  = '0;
        rd_addr  = r_h[AW-1:0];
        wr_addr  = r_h[AW-1:0];
        wr_free  = 1'b1;
        wr_cap   = r_cap[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func = i_func;
                    n_req  = i_req_size;
                    if (i_func == FUNC_FREE) begin
                        if (fa < C_HDR || fh >= C_ARENA) begin
                            // null or out-of-range free: nothing to do
                            n_done   = 1'b1;
                            n_status = 1'b0;
                            n_addr   = '0;
                        end else begin
                            n_h           = fh;
                            mem_ctl.rd_en = 1'b1;
                            rd_addr       = fh[AW-1:0];
                            n_state       = S_F_HDR;
                        end
                    end else begin
                        n_h     = '0;
                        n_state = S_A_CHK;
                    end
                end
            end
            S_A_CHK: begin
                if (r_h < C_ARENA && r_h + C_HDR <= C_ARENA) begin
                    mem_ctl.rd_en = 1'b1;
                    n_state       = S_A_HDR;
                end else begin
                    n_done   = 1'b1;
                    n_status = 1'b1;
                    n_addr   = '0;
                    n_state  = S_IDLE;
                end
            end
            S_A_HDR: begin
                if (m_free) begin
                    n_cap   = SW'(m_cap);
                    n_state = S_M_RD;
                end else begin
                    n_h     = mem_end;
                    n_state = S_A_CHK;
                end
            end
            S_F_HDR: begin
                mem_ctl.wr_en = 1'b1;
                wr_cap        = m_cap;
                n_cap         = SW'(m_cap);
                n_state       = S_M_RD;
            end
            S_M_RD: begin
                if (nx < C_ARENA) begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = nx[AW-1:0];
                    n_state       = S_M_CMP;
                end else if (r_func == FUNC_FREE) begin
                    n_done   = 1'b1;
                    n_status = 1'b0;
                    n_addr   = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_FIT;
                end
            end
            S_M_CMP: begin
                if (m_free) begin
                    mem_ctl.wr_en = 1'b1;
                    wr_cap        = sat[AW-1:0];
                    n_cap         = sat;
                end
                if (r_func == FUNC_FREE) begin
                    // free merges only once
                    n_done   = 1'b1;
                    n_status = 1'b0;
                    n_addr   = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_state = m_free ? S_M_RD : S_FIT;
                end
            end
            S_FIT: begin
                if (r_cap >= req_w) begin
                    if (q_w + C_HDR + C_MIN <= r_cap) begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = rest[AW-1:0];
                        wr_cap        = rest_cap[AW-1:0];
                        n_cap         = q_w;
                    end
                    n_state = S_WR_H;
                end else begin
                    n_h     = nx;
                    n_state = S_A_CHK;
                end
            end
            S_WR_H: begin
                mem_ctl.wr_en = 1'b1;
                wr_free       = 1'b0;
                n_done        = 1'b1;
                n_status      = 1'b0;
                n_addr        = nx[11:0] - r_cap[11:0];
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_req    <= n_req;
        r_h      <= n_h;
        r_cap    <= n_cap;
        r_status <= n_status;
        r_addr   <= n_addr;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_data_addr = r_addr;

    // Result cycle always finds the block ready for the next transaction
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while busy");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_data_addr == '0))
        else $error("failed allocation carries an address");

    // Read and write of the same header in one cycle would return stale data
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_ctl.rd_en && mem_ctl.wr_en) |-> (rd_addr != wr_addr))
        else $error("header read and write collide");

endmodule

// ===== rtl/ffa_block_mem.sv =====
// Block header store: free flag and capacity per header offset.
// One write and one registered read per cycle. Depends on ffa_pkg.
module ffa_block_mem #(
    parameter int ARENA_BYTES  = ffa_pkg::ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
    localparam int AW = $clog2(ARENA_BYTES)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ffa_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic             i_wr_free,
    input  logic [AW-1:0]    i_wr_cap,
    output logic             o_rd_free,
    output logic [AW-1:0]    o_rd_cap
);

    localparam logic [AW-1:0] CAP0 = AW'(ARENA_BYTES - HEADER_BYTES);

    logic [AW:0] mem [ARENA_BYTES];
    logic [AW:0] r_rd_data;
    logic        r_rd_zero;
    logic        r_e0_written;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= {i_wr_free, i_wr_cap};
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // Entry 0 holds the whole free arena until its first write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e0_written <= 1'b0;
            r_rd_zero    <= 1'b0;
        end else begin
            if (i_ctl.wr_en && i_wr_addr == '0) begin
                r_e0_written <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_zero <= (i_rd_addr == '0) && !r_e0_written;
            end
        end
    end

    assign o_rd_free = r_rd_zero ? 1'b1 : r_rd_data[AW];
    assign o_rd_cap  = r_rd_zero ? CAP0 : r_rd_data[AW-1:0];

endmodule
